FILE: design/chq_pkg.sv
// Package for the capacitive touch hysteresis qualifier.
// Holds field widths, register indexes and the structs shared by the modules.
// No dependencies.
package chq_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int CONFIRM_W   = 8;
   localparam int MASK_W      = 2;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [SAMPLE_W-1:0]  DELTA_MIN_RST    = 16'd32;
   localparam logic [SAMPLE_W-1:0]  MIN_THRESH_RST   = 16'd0;
   localparam logic [SAMPLE_W-1:0]  HYSTERESIS_RST   = 16'd16;
   localparam logic [CONFIRM_W-1:0] PRESS_CONF_RST   = 8'd3;
   localparam logic [CONFIRM_W-1:0] RELEASE_CONF_RST = 8'd3;

   typedef enum logic [2:0] {
      REG_DELTA_MIN       = 3'd0,
      REG_MIN_THRESHOLD   = 3'd1,
      REG_RELEASE_HYST    = 3'd2,
      REG_PRESS_CONFIRM   = 3'd3,
      REG_RELEASE_CONFIRM = 3'd4
   } reg_type;

   typedef enum logic {
      MODE_CALIBRATE = 1'b0,
      MODE_DETECT    = 1'b1
   } mode_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  delta_min;
      logic [SAMPLE_W-1:0]  min_threshold;
      logic [SAMPLE_W-1:0]  release_hysteresis;
      logic [CONFIRM_W-1:0] press_confirm;
      logic [CONFIRM_W-1:0] release_confirm;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  baseline;
      logic [CONFIRM_W-1:0] press_count;
      logic [CONFIRM_W-1:0] release_count;
      logic                 pressed;
   } det_state_type;

endpackage

FILE: design/cap_touch_hysteresis_qualifier.sv
// Top level of the capacitive touch hysteresis qualifier: input register,
// per-channel state, result register. Depends on chq_pkg, chq_csr, chq_update.
//
//   port group   direction   handshake          contents
//   req_         in          valid / stall      mode, channel, sample
//   rsp_         out         valid / stall      pressed_mask, channel_baseline
//   csr_         in/out      psel / penable     five config registers, 4-byte stride
//
// One item per cycle while req_stall is low; an item's result reaches rsp_ through
// the input register, then one pass of update logic into the result register;
// while rsp_stall keeps the result register full, the item waits in the input register.
// The per-channel state is written in the same edge as the result, so items
// for the same channel follow each other without gaps.
// reset is synchronous: all channels released, baselines and counters zero,
// registers back to their defaults. req_stall rises only while both the input
// and the result register hold an item and rsp_stall is high.
module cap_touch_hysteresis_qualifier #(
   parameter int CHANNELS         = 2,
   parameter int RATIO_DIV        = 8,
   parameter int BASELINE_SAMPLES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_mode,
   input  logic                             req_channel,
   input  logic [chq_pkg::SAMPLE_W-1:0]     req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [chq_pkg::MASK_W-1:0]       rsp_pressed_mask,
   output logic [chq_pkg::SAMPLE_W-1:0]     rsp_channel_baseline,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [chq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [chq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [chq_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int SUM_W = chq_pkg::SAMPLE_W + $clog2(BASELINE_SAMPLES);
   localparam int CNT_W = $clog2(BASELINE_SAMPLES + 1);

   chq_pkg::cfg_type       cfg;

   logic                          s1_valid_ff;
   logic                          s1_mode_ff;
   logic                          s1_channel_ff;
   logic [chq_pkg::SAMPLE_W-1:0]  s1_sample_ff;

   logic                          rsp_valid_ff;
   logic [chq_pkg::MASK_W-1:0]    rsp_mask_ff;
   logic [chq_pkg::SAMPLE_W-1:0]  rsp_base_ff;
   logic [chq_pkg::MASK_W-1:0]    rsp_mask_in;
   logic [chq_pkg::SAMPLE_W-1:0]  rsp_base_in;

   chq_pkg::det_state_type        det_ff [CHANNELS];
   logic [SUM_W-1:0]              sum_ff [CHANNELS];
   logic [CNT_W-1:0]              cnt_ff [CHANNELS];

   chq_pkg::det_state_type        cur_det;
   logic [SUM_W-1:0]              cur_sum;
   logic [CNT_W-1:0]              cur_cnt;
   chq_pkg::det_state_type        det_in;
   logic [SUM_W-1:0]              sum_in;
   logic [CNT_W-1:0]              cnt_in;

   logic [CHANNELS-1:0]           hit;
   logic                          ch_ok;
   logic                          advance;
   logic                          fire;

   chq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign fire      = s1_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_mode_ff    <= req_mode;
         s1_channel_ff <= req_channel;
         s1_sample_ff  <= req_sample;
      end
   end

   always_comb begin
      cur_det = '0;
      cur_sum = '0;
      cur_cnt = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         hit[c] = (32'(s1_channel_ff) == c);
         if (hit[c]) begin
            cur_det = det_ff[c];
            cur_sum = sum_ff[c];
            cur_cnt = cnt_ff[c];
         end
      end
      ch_ok = |hit;
   end

   chq_update #(
      .RATIO_DIV        (RATIO_DIV),
      .BASELINE_SAMPLES (BASELINE_SAMPLES),
      .SUM_W            (SUM_W),
      .CNT_W            (CNT_W)
   ) u_update (
      .cfg     (cfg),
      .mode    (chq_pkg::mode_type'(s1_mode_ff)),
      .sample  (s1_sample_ff),
      .cur     (cur_det),
      .cur_sum (cur_sum),
      .cur_cnt (cur_cnt),
      .nxt     (det_in),
      .nxt_sum (sum_in),
      .nxt_cnt (cnt_in)
   );

   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (reset) begin
            det_ff[c] <= '0;
            sum_ff[c] <= '0;
            cnt_ff[c] <= '0;
         end else if (fire && hit[c]) begin
            det_ff[c] <= det_in;
            sum_ff[c] <= sum_in;
            cnt_ff[c] <= cnt_in;
         end
      end
   end

   always_comb begin
      rsp_mask_in = '0;
      for (int c = 0; c < CHANNELS && c < chq_pkg::MASK_W; c++) begin
         rsp_mask_in[c[0]] = hit[c] ? det_in.pressed : det_ff[c].pressed;
      end
      rsp_base_in = ch_ok ? det_in.baseline : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_mask_ff <= rsp_mask_in;
         rsp_base_ff <= rsp_base_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pressed_mask     = rsp_mask_ff;
   assign rsp_channel_baseline = rsp_base_ff;

endmodule

FILE: design/chq_csr.sv
// Configuration register file of the touch qualifier, APB-style access.
// Depends on chq_pkg.
module chq_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [chq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [chq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [chq_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output chq_pkg::cfg_type                 cfg
);

   chq_pkg::cfg_type cfg_ff;
   chq_pkg::reg_type reg_idx;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = chq_pkg::reg_type'(csr_paddr[4:2]);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delta_min          <= chq_pkg::DELTA_MIN_RST;
         cfg_ff.min_threshold      <= chq_pkg::MIN_THRESH_RST;
         cfg_ff.release_hysteresis <= chq_pkg::HYSTERESIS_RST;
         cfg_ff.press_confirm      <= chq_pkg::PRESS_CONF_RST;
         cfg_ff.release_confirm    <= chq_pkg::RELEASE_CONF_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            chq_pkg::REG_DELTA_MIN: begin
               cfg_ff.delta_min <= csr_pwdata[chq_pkg::SAMPLE_W-1:0];
            end
            chq_pkg::REG_MIN_THRESHOLD: begin
               cfg_ff.min_threshold <= csr_pwdata[chq_pkg::SAMPLE_W-1:0];
            end
            chq_pkg::REG_RELEASE_HYST: begin
               cfg_ff.release_hysteresis <= csr_pwdata[chq_pkg::SAMPLE_W-1:0];
            end
            chq_pkg::REG_PRESS_CONFIRM: begin
               cfg_ff.press_confirm <= csr_pwdata[chq_pkg::CONFIRM_W-1:0];
            end
            chq_pkg::REG_RELEASE_CONFIRM: begin
               cfg_ff.release_confirm <= csr_pwdata[chq_pkg::CONFIRM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         chq_pkg::REG_DELTA_MIN:       csr_prdata = 32'(cfg_ff.delta_min);
         chq_pkg::REG_MIN_THRESHOLD:   csr_prdata = 32'(cfg_ff.min_threshold);
         chq_pkg::REG_RELEASE_HYST:    csr_prdata = 32'(cfg_ff.release_hysteresis);
         chq_pkg::REG_PRESS_CONFIRM:   csr_prdata = 32'(cfg_ff.press_confirm);
         chq_pkg::REG_RELEASE_CONFIRM: csr_prdata = 32'(cfg_ff.release_confirm);
         default:                      csr_prdata = '0;
      endcase
   end

endmodule

FILE: design/chq_update.sv
// Next-state logic for one channel: baseline averaging, adaptive thresholds
// and press/release debounce. Depends on chq_pkg.
module chq_update #(
   parameter int RATIO_DIV        = 8,
   parameter int BASELINE_SAMPLES = 16,
   parameter int SUM_W            = 20,
   parameter int CNT_W            = 5
) (
   input  chq_pkg::cfg_type                cfg,
   input  chq_pkg::mode_type               mode,
   input  logic [chq_pkg::SAMPLE_W-1:0]    sample,
   input  chq_pkg::det_state_type          cur,
   input  logic [SUM_W-1:0]                cur_sum,
   input  logic [CNT_W-1:0]                cur_cnt,
   output chq_pkg::det_state_type          nxt,
   output logic [SUM_W-1:0]                nxt_sum,
   output logic [CNT_W-1:0]                nxt_cnt
);

   // sum / BASELINE_SAMPLES and baseline / RATIO_DIV by exact reciprocal multiply
   localparam int          CAL_LOG   = $clog2(BASELINE_SAMPLES);
   localparam int          CAL_SHIFT = SUM_W + CAL_LOG;
   localparam int          CAL_PW    = 2 * SUM_W + 1;
   localparam logic [63:0] CAL_MUL   = ((64'd1 << CAL_SHIFT) + 64'(BASELINE_SAMPLES) - 64'd1)
                                       / 64'(BASELINE_SAMPLES);
   localparam int          RAT_LOG   = $clog2(RATIO_DIV);
   localparam int          RAT_SHIFT = chq_pkg::SAMPLE_W + RAT_LOG;
   localparam int          RAT_PW    = RAT_SHIFT + chq_pkg::SAMPLE_W + 1;
   localparam logic [63:0] RAT_MUL   = ((64'd1 << RAT_SHIFT) + 64'(RATIO_DIV) - 64'd1)
                                       / 64'(RATIO_DIV);
   localparam int          SW        = chq_pkg::SAMPLE_W;

   logic [CAL_PW-1:0] cal_prod;
   logic [RAT_PW-1:0] rat_prod;
   logic [SUM_W-1:0]  sum_inc;
   logic [CNT_W-1:0]  cnt_inc;
   logic [SW-1:0]     base_frac;
   logic [SW+1:0]     raw_thresh;
   logic [SW-1:0]     press_th;
   logic [SW-1:0]     release_th;

   always_comb begin
      sum_inc    = cur_sum + SUM_W'(sample);
      cnt_inc    = cur_cnt + CNT_W'(1);
      cal_prod   = CAL_PW'(sum_inc) * CAL_PW'(CAL_MUL[SUM_W:0]);
      rat_prod   = RAT_PW'(cur.baseline) * RAT_PW'(RAT_MUL[SW:0]);
      base_frac  = rat_prod[RAT_SHIFT +: SW];
      raw_thresh = (SW+2)'(cur.baseline) + (SW+2)'(base_frac) + (SW+2)'(cfg.delta_min);
      press_th   = (raw_thresh[SW-1:0] < cfg.min_threshold) ? cfg.min_threshold
                                                            : raw_thresh[SW-1:0];
      if ((SW+1)'(press_th) > (SW+1)'(cur.baseline) + (SW+1)'(cfg.release_hysteresis)) begin
         release_th = press_th - cfg.release_hysteresis;
      end else begin
         release_th = cur.baseline;
      end

      nxt     = cur;
      nxt_sum = cur_sum;
      nxt_cnt = cur_cnt;

      unique case (mode)
         chq_pkg::MODE_CALIBRATE: begin
            nxt_sum = sum_inc;
            nxt_cnt = cnt_inc;
            if (cnt_inc >= CNT_W'(BASELINE_SAMPLES)) begin
               nxt.baseline      = cal_prod[CAL_SHIFT +: SW];
               nxt_sum           = '0;
               nxt_cnt           = '0;
               nxt.press_count   = '0;
               nxt.release_count = '0;
               nxt.pressed       = 1'b0;
            end
         end
         chq_pkg::MODE_DETECT: begin
            if (cur.pressed) begin
               if (sample == '0 || sample <= release_th) begin
                  if (cur.release_count < cfg.release_confirm) begin
                     nxt.release_count = cur.release_count + 8'd1;
                  end
               end else begin
                  nxt.release_count = '0;
               end
               if (nxt.release_count >= cfg.release_confirm) begin
                  nxt.pressed     = 1'b0;
                  nxt.press_count = '0;
               end
            end else begin
               if (sample >= press_th) begin
                  if (cur.press_count < cfg.press_confirm) begin
                     nxt.press_count = cur.press_count + 8'd1;
                  end
               end else begin
                  nxt.press_count = '0;
                  if (sample != '0 && sample < cur.baseline) begin
                     nxt.baseline = sample;
                  end
               end
               if (nxt.press_count >= cfg.press_confirm) begin
                  nxt.pressed       = 1'b1;
                  nxt.release_count = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: design/chq_checker.sv
// Port-level checks for the touch qualifier and the bind that attaches them.
// Depends on chq_pkg and cap_touch_hysteresis_qualifier.
module chq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [chq_pkg::MASK_W-1:0]       rsp_pressed_mask,
   input logic [chq_pkg::SAMPLE_W-1:0]     rsp_channel_baseline
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pressed_mask)
                                 && $stable(rsp_channel_baseline))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input side never waits while the result register is empty
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without downstream backpressure");

endmodule

bind cap_touch_hysteresis_qualifier chq_checker u_chq_checker (.*);
